@@ design/subleq_pkg.sv @@
// ----------------------------------------------------------------------------
// subleq_pkg
// Shared types and codes for the SUBLEQ core: function codes, special operand
// codes, sequencer states and the execute-unit result bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package subleq_pkg;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned CHAR_W = 9;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_STEP  = 2'd1;
    localparam logic [1:0] FUNC_PCCLR = 2'd2;

    localparam logic [WORD_W-1:0] OP_INPUT  = 16'hFFFF;
    localparam logic [WORD_W-1:0] OP_SHR    = 16'hFFFE;
    localparam logic [WORD_W-1:0] OP_SHL    = 16'hFFFD;
    localparam logic [WORD_W-1:0] OP_SPR_HI = 16'hFFFC;
    localparam logic [WORD_W-1:0] OP_SPR_LO = 16'hFFFB;
    localparam logic [WORD_W-1:0] IO_PORT   = 16'hFFFF;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_REPORT,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_FETCH_C,
        ST_READ_B,
        ST_READ_A,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic              wr_en;
        logic [WORD_W-1:0] wr_data;
        logic              jump;
        logic              took;
        logic              out_valid;
        logic [7:0]        out_char;
    } exec_res_t;

endpackage

@@ design/subleq_ram.sv @@
// ----------------------------------------------------------------------------
// subleq_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module subleq_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ design/subleq_amod.sv @@
// ----------------------------------------------------------------------------
// subleq_amod
// Address folding: 16-bit address modulo the memory depth, by a registered
// reciprocal multiply, then back-multiply and a single correction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module subleq_amod #(
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     clk,
    input  logic [15:0]              x,
    output logic [$clog2(DEPTH)-1:0] idx
);

    localparam int unsigned AW    = $clog2(DEPTH);
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / DEPTH);
    localparam logic [16:0] DEP17 = 17'(DEPTH);

    logic [48:0] prod;
    logic [15:0] x_reg;
    logic [15:0] q_reg;
    logic [31:0] qd;
    logic [16:0] diff;
    logic [16:0] rem;

    assign prod = 49'(x) * 49'(RECIP);

    always_ff @(posedge clk)
    begin
        x_reg <= x;
        q_reg <= prod[47:32];
    end

    always_comb
    begin
        qd   = 32'(q_reg) * 32'(DEPTH);
        diff = {1'b0, x_reg} - qd[16:0];
        if (diff >= DEP17)
        begin
            rem = diff - DEP17;
        end
        else
        begin
            rem = diff;
        end
    end

    assign idx = rem[AW-1:0];

endmodule

@@ design/subleq_exec.sv @@
// ----------------------------------------------------------------------------
// subleq_exec
// Execute unit: decodes the a and b operands and forms the value written to
// m[b], the branch decision and the character port activity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module subleq_exec
    import subleq_pkg::*;
(
    input  logic [WORD_W-1:0] op_a,
    input  logic [WORD_W-1:0] op_b,
    input  logic [WORD_W-1:0] mem_a,
    input  logic [WORD_W-1:0] mem_b,
    input  logic [CHAR_W-1:0] in_char,
    output exec_res_t         res
);

    logic [WORD_W-1:0] diff;

    assign diff = mem_b - mem_a;

    always_comb
    begin
        res           = '0;
        res.wr_en     = 1'b1;
        unique case (op_a)
            OP_INPUT:
            begin
                res.wr_data = {{(WORD_W-CHAR_W){in_char[CHAR_W-1]}}, in_char};
                res.took    = 1'b1;
            end
            OP_SHR:    res.wr_data = {1'b0, mem_b[WORD_W-1:1]};
            OP_SHL:    res.wr_data = {mem_b[WORD_W-2:0], 1'b0};
            OP_SPR_HI: res.wr_data = {WORD_W{mem_b[WORD_W-1]}};
            OP_SPR_LO: res.wr_data = {WORD_W{mem_b[0]}};
            default:
            begin
                if (op_b == IO_PORT)
                begin
                    res.wr_en     = 1'b0;
                    res.out_valid = 1'b1;
                    res.out_char  = mem_a[7:0];
                end
                else
                begin
                    res.wr_data = diff;
                    res.jump    = diff[WORD_W-1] || (diff == '0);
                end
            end
        endcase
    end

endmodule

@@ design/subleq_cpu_core_unit.sv @@
// ----------------------------------------------------------------------------
// subleq_cpu_core_unit
// 16-bit SUBLEQ core with a single-port word memory.
//
// Command channel: func, addr, load_data and in_char are taken at a rising
// edge with start high and busy low. Every command gives exactly one result
// word: done is high for one cycle with out_valid, out_char, took_input,
// halted and prog_counter; the receiver cannot stall it.
// A load goes through ST_LOAD; pc clear, step while halted and unused codes
// go through ST_REPORT; an executed step goes through ST_FETCH_A, ST_FETCH_B,
// ST_FETCH_C, ST_READ_B, ST_READ_A and ST_WRITE, since the single memory port
// needs one access each for three fetches, reads of m[b] and m[a], and the
// write-back of m[b]. The next command can be taken in the cycle done is shown.
// Reset: pc goes to zero and a clearing pass writes zero to every memory word,
// one word a cycle, with busy high.
// Addresses fold modulo MEM_DEPTH; a step while pc bit 15 is set changes
// nothing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module subleq_cpu_core_unit
    import subleq_pkg::*;
#(
    parameter int unsigned MEM_DEPTH = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        func,
    input  logic [15:0]       addr,
    input  logic [15:0]       load_data,
    input  logic signed [8:0] in_char,
    output logic              done,
    output logic              out_valid,
    output logic [7:0]        out_char,
    output logic              took_input,
    output logic              halted,
    output logic [15:0]       prog_counter
);

    localparam int unsigned AW = $clog2(MEM_DEPTH);

    state_t            state_reg;
    state_t            state_next;
    logic [AW-1:0]     clr_cnt_reg;
    logic [15:0]       pc_reg;
    logic [15:0]       a_reg;
    logic [15:0]       b_reg;
    logic [15:0]       c_reg;
    logic [15:0]       mb_reg;
    logic [15:0]       data_reg;
    logic [CHAR_W-1:0] char_reg;

    logic              done_reg;
    logic              out_valid_reg;
    logic [7:0]        out_char_reg;
    logic              took_reg;
    logic [15:0]       pc_out_reg;

    logic              accept;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [15:0]       ram_wdata;
    logic [15:0]       ram_rdata;
    logic [15:0]       mod_in;
    logic [AW-1:0]     mod_idx;
    exec_res_t         ex_res;
    logic [15:0]       pc_after;

    assign accept = start && !busy;

    subleq_ram #(
        .WIDTH (16),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    subleq_amod #(
        .DEPTH (MEM_DEPTH)
    ) u_amod (
        .clk (clk),
        .x   (mod_in),
        .idx (mod_idx)
    );

    subleq_exec u_exec (
        .op_a    (a_reg),
        .op_b    (b_reg),
        .mem_a   (ram_rdata),
        .mem_b   (mb_reg),
        .in_char (char_reg),
        .res     (ex_res)
    );

    assign pc_after = ex_res.jump ? c_reg : pc_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_LOAD)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (func == FUNC_STEP && !pc_reg[15])
                    begin
                        state_next = ST_FETCH_A;
                    end
                    else
                    begin
                        state_next = ST_REPORT;
                    end
                end
            end
            ST_LOAD:    state_next = ST_IDLE;
            ST_REPORT:  state_next = ST_IDLE;
            ST_FETCH_A: state_next = ST_FETCH_B;
            ST_FETCH_B: state_next = ST_FETCH_C;
            ST_FETCH_C: state_next = ST_READ_B;
            ST_READ_B:  state_next = ST_READ_A;
            ST_READ_A:  state_next = ST_WRITE;
            ST_WRITE:   state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // memory port and address folding
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = mod_idx;
        ram_wdata = ex_res.wr_data;
        mod_in    = pc_reg;
        busy      = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                busy   = 1'b0;
                mod_in = (func == FUNC_LOAD) ? addr : pc_reg;
            end
            ST_LOAD:
            begin
                ram_we    = 1'b1;
                ram_wdata = data_reg;
            end
            ST_FETCH_A: mod_in = pc_reg + 16'd1;
            ST_FETCH_B: mod_in = pc_reg + 16'd1;
            ST_FETCH_C: mod_in = ram_rdata;
            ST_READ_B:  mod_in = a_reg;
            ST_READ_A:  mod_in = b_reg;
            ST_WRITE:   ram_we = ex_res.wr_en;
            default:    ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pc_reg        <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            took_reg      <= 1'b0;
            pc_out_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (accept && func == FUNC_PCCLR)
            begin
                pc_reg <= '0;
            end
            if (state_reg == ST_FETCH_A || state_reg == ST_FETCH_B
                || state_reg == ST_FETCH_C)
            begin
                pc_reg <= pc_reg + 16'd1;
            end
            if (state_reg == ST_LOAD || state_reg == ST_REPORT)
            begin
                done_reg      <= 1'b1;
                out_valid_reg <= 1'b0;
                out_char_reg  <= '0;
                took_reg      <= 1'b0;
                pc_out_reg    <= pc_reg;
            end
            if (state_reg == ST_WRITE)
            begin
                pc_reg        <= pc_after;
                done_reg      <= 1'b1;
                out_valid_reg <= ex_res.out_valid;
                out_char_reg  <= ex_res.out_char;
                took_reg      <= ex_res.took;
                pc_out_reg    <= pc_after;
            end
        end
    end

    // operand holding
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= load_data;
            char_reg <= in_char;
        end
        if (state_reg == ST_FETCH_B)
        begin
            a_reg <= ram_rdata;
        end
        if (state_reg == ST_FETCH_C)
        begin
            b_reg <= ram_rdata;
        end
        if (state_reg == ST_READ_B)
        begin
            c_reg <= ram_rdata;
        end
        if (state_reg == ST_READ_A)
        begin
            mb_reg <= ram_rdata;
        end
    end

    assign done         = done_reg;
    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign took_input   = took_reg;
    assign prog_counter = pc_out_reg;
    assign halted       = pc_out_reg[15];

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("command taken but core not busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_io_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(out_valid && took_input))
        else $error("input and output in one step");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_LOAD
                    || state_reg == ST_WRITE))
        else $error("memory write outside a write state");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !done)
        else $error("result during clearing pass");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for subleq_cpu_core_unit. Sends load, step, pc-clear and
// unused commands through the start/busy handshake. Predicts each result word
// with a private memory and pc copy, and checks every done strobe field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import subleq_pkg::*;

    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam logic [15:0] DATA_BASE   = 16'd64;
    localparam int          ITEM_TARGET = 1020;
    localparam int          PRINT_CAP   = 50;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_char;
        logic        took;
        logic        halted;
        logic [15:0] pc;
    } core_word_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        func;
    logic [15:0]       addr;
    logic [15:0]       load_data;
    logic signed [8:0] in_char;
    logic              done;
    logic              out_valid;
    logic [7:0]        out_char;
    logic              took_input;
    logic              halted;
    logic [15:0]       prog_counter;

    logic [15:0] core_mem [0:65535];
    logic [15:0] core_pc;
    core_word_t  pending_words [$];
    core_word_t  want_word;
    int          mismatch_count;
    int          words_sent;
    int          burst_left;

    subleq_cpu_core_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .addr         (addr),
        .load_data    (load_data),
        .in_char      (in_char),
        .done         (done),
        .out_valid    (out_valid),
        .out_char     (out_char),
        .took_input   (took_input),
        .halted       (halted),
        .prog_counter (prog_counter)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic core_word_t predict_core(input logic [1:0] f, input logic [15:0] a,
                                                input logic [15:0] d, input logic [8:0] ch);
        core_word_t  res;
        logic [15:0] op_a;
        logic [15:0] op_b;
        logic [15:0] op_c;
        logic [15:0] mb;
        logic [15:0] diff;
        res = '0;
        if (f == FUNC_LOAD)
            core_mem[a] = d;
        else if (f == FUNC_PCCLR)
            core_pc = '0;
        else if (f == FUNC_STEP && !core_pc[15])
        begin
            op_a = core_mem[core_pc];
            core_pc = core_pc + 16'd1;
            op_b = core_mem[core_pc];
            core_pc = core_pc + 16'd1;
            op_c = core_mem[core_pc];
            core_pc = core_pc + 16'd1;
            mb = core_mem[op_b];
            if (op_a == OP_INPUT)
            begin
                core_mem[op_b] = {{7{ch[8]}}, ch};
                res.took = 1'b1;
            end
            else if (op_a == OP_SHR)
                core_mem[op_b] = mb >> 1;
            else if (op_a == OP_SHL)
                core_mem[op_b] = mb << 1;
            else if (op_a == OP_SPR_HI)
                core_mem[op_b] = {16{mb[15]}};
            else if (op_a == OP_SPR_LO)
                core_mem[op_b] = {16{mb[0]}};
            else if (op_b == IO_PORT)
            begin
                res.out_valid = 1'b1;
                res.out_char = core_mem[op_a][7:0];
            end
            else
            begin
                diff = mb - core_mem[op_a];
                if (diff[15] || diff == 16'd0)
                    core_pc = op_c;
                core_mem[op_b] = diff;
            end
        end
        res.halted = core_pc[15];
        res.pc = core_pc;
        return res;
    endfunction

    function automatic int next_burst();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(30, 80);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH %0t %s: got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_word(input logic [1:0] f, input logic [15:0] a,
                             input logic [15:0] d, input logic [8:0] ch);
        @(negedge clk);
        start     <= 1'b1;
        func      <= f;
        addr      <= a;
        load_data <= d;
        in_char   <= ch;
        do
            @(posedge clk);
        while (busy);
        pending_words.push_back(predict_core(f, a, d, ch));
        words_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            pause_sender($urandom_range(1, 15));
            burst_left = next_burst();
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
                report_mismatch("unexpected word", prog_counter, 16'h0);
            else
            begin
                want_word = pending_words.pop_front();
                if (out_valid !== want_word.out_valid)
                    report_mismatch("out_valid", 16'(out_valid), 16'(want_word.out_valid));
                if (out_char !== want_word.out_char)
                    report_mismatch("out_char", 16'(out_char), 16'(want_word.out_char));
                if (took_input !== want_word.took)
                    report_mismatch("took_input", 16'(took_input), 16'(want_word.took));
                if (halted !== want_word.halted)
                    report_mismatch("halted", 16'(halted), 16'(want_word.halted));
                if (prog_counter !== want_word.pc)
                    report_mismatch("prog_counter", prog_counter, want_word.pc);
            end
        end
    end

    task automatic test_load_extremes();
        send_word(FUNC_STEP, 16'h0000, 16'h0000, 9'h000);
        send_word(FUNC_LOAD, 16'hFFFF, 16'hFFFF, 9'h1FF);
    endtask

    task automatic test_special_ops();
        send_word(FUNC_LOAD, 16'd0, OP_INPUT, 9'h000);
        send_word(FUNC_LOAD, 16'd1, 16'd40, 9'h000);
        send_word(FUNC_LOAD, 16'd3, OP_SHR, 9'h000);
        send_word(FUNC_LOAD, 16'd4, 16'd40, 9'h000);
        send_word(FUNC_LOAD, 16'd6, OP_SHL, 9'h000);
        send_word(FUNC_LOAD, 16'd7, 16'd40, 9'h000);
        send_word(FUNC_LOAD, 16'd9, OP_SPR_HI, 9'h000);
        send_word(FUNC_LOAD, 16'd10, 16'd40, 9'h000);
        send_word(FUNC_LOAD, 16'd12, OP_SPR_LO, 9'h000);
        send_word(FUNC_LOAD, 16'd13, 16'd40, 9'h000);
        send_word(FUNC_LOAD, 16'd15, 16'd40, 9'h000);
        send_word(FUNC_LOAD, 16'd16, IO_PORT, 9'h000);
        send_word(FUNC_LOAD, 16'd18, 16'd40, 9'h000);
        send_word(FUNC_LOAD, 16'd19, 16'd41, 9'h000);
        send_word(FUNC_LOAD, 16'd21, 16'd41, 9'h000);
        send_word(FUNC_LOAD, 16'd22, 16'd42, 9'h000);
        send_word(FUNC_LOAD, 16'd23, 16'h8000, 9'h000);
        send_word(FUNC_STEP, 16'h0000, 16'h0000, 9'h1FF);
        repeat (6) send_word(FUNC_STEP, 16'h0000, 16'h0000, 9'(($urandom_range(0, 511))));
        send_word(FUNC_STEP, 16'h0000, 16'h0000, 9'h000);
        wait_drained();
    endtask

    task automatic test_halt_and_unused();
        send_word(FUNC_STEP, 16'hFFFF, 16'hFFFF, 9'h1FF);
        send_word(FUNC_UNUSED, 16'hA5A5, 16'h5A5A, 9'h0AA);
        send_word(FUNC_PCCLR, 16'h5A5A, 16'hA5A5, 9'h155);
        send_word(FUNC_STEP, 16'h0000, 16'h0000, 9'h0FF);
    endtask

    function automatic logic [15:0] pick_src(input int n_instr);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return DATA_BASE + 16'($urandom_range(0, 15));
        else if (sel < 75)
            return OP_SPR_LO + 16'($urandom_range(0, 4));
        else if (sel < 90)
            return 16'($urandom_range(0, 3 * n_instr - 1));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_dst(input int n_instr);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 78)
            return DATA_BASE + 16'($urandom_range(0, 15));
        else if (sel < 90)
            return IO_PORT;
        else if (sel < 95)
            return 16'($urandom_range(0, 3 * n_instr - 1));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_target(input int n_instr);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 16'(3 * $urandom_range(0, n_instr - 1));
        else if (sel < 75)
            return 16'h8000 | 16'($urandom);
        else if (sel < 85)
            return 16'($urandom_range(0, 3 * n_instr - 1));
        else if (sel < 92)
            return 16'h7FFD + 16'($urandom_range(0, 2));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [8:0] pick_char();
        return ($urandom_range(0, 9) == 0) ? 9'h1FF : 9'($urandom_range(0, 511));
    endfunction

    task automatic test_random_programs();
        int n_instr;
        int n_steps;
        int episode;
        episode = 0;
        while (words_sent < ITEM_TARGET)
        begin
            n_instr = $urandom_range(1, 8);
            for (int k = 0; k < n_instr; k++)
            begin
                send_word(FUNC_LOAD, 16'(3 * k), pick_src(n_instr), pick_char());
                send_word(FUNC_LOAD, 16'(3 * k + 1), pick_dst(n_instr), pick_char());
                send_word(FUNC_LOAD, 16'(3 * k + 2), pick_target(n_instr), pick_char());
            end
            repeat ($urandom_range(1, 5))
                send_word(FUNC_LOAD, DATA_BASE + 16'($urandom_range(0, 15)), pick_value(),
                          pick_char());
            if ($urandom_range(0, 4) != 0)
                send_word(FUNC_PCCLR, 16'($urandom), 16'($urandom), pick_char());
            n_steps = $urandom_range(n_instr, 4 * n_instr + 4);
            for (int s = 0; s < n_steps; s++)
            begin
                case ($urandom_range(0, 24))
                    0: send_word(FUNC_UNUSED, 16'($urandom), 16'($urandom), pick_char());
                    1: send_word(FUNC_LOAD, 16'($urandom), 16'($urandom), pick_char());
                    2: send_word(FUNC_PCCLR, 16'($urandom), 16'($urandom), pick_char());
                    default: send_word(FUNC_STEP, 16'($urandom), 16'($urandom), pick_char());
                endcase
            end
            episode++;
            if (episode % 10 == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        func           = FUNC_LOAD;
        addr           = '0;
        load_data      = '0;
        in_char        = '0;
        mismatch_count = 0;
        words_sent     = 0;
        burst_left     = next_burst();
        core_pc        = '0;
        for (int i = 0; i < 65536; i++)
            core_mem[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_load_extremes();
        test_special_ops();
        test_halt_and_unused();
        test_random_programs();

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
